// ===== rtl/core/indexed_list_store_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_UNIT_DEFINES_SVH
`define INDEXED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ILS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ILS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ils_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store package
// Request/response payloads, operation and status codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Operation codes
  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_POP_BACK  = 3'd1;
  localparam logic [2:0] OP_PREPEND   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;
  localparam logic [2:0] OP_WRITE     = 3'd5;
  localparam logic [2:0] OP_INSERT    = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Read address select
  localparam logic [1:0] RD_TGT    = 2'd0;
  localparam logic [1:0] RD_LAST   = 2'd1;
  localparam logic [1:0] RD_PTR_DN = 2'd2;
  localparam logic [1:0] RD_PTR_UP = 2'd3;

  // Write source/address select
  localparam logic WR_WORD_TGT  = 1'b0;
  localparam logic WR_RDATA_PTR = 1'b1;

  // Pointer update
  localparam logic [2:0] PTR_HOLD     = 3'd0;
  localparam logic [2:0] PTR_LOAD_CNT = 3'd1;
  localparam logic [2:0] PTR_ZERO     = 3'd2;
  localparam logic [2:0] PTR_DEC      = 3'd3;
  localparam logic [2:0] PTR_INC      = 3'd4;

  // Fill count update
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  position;
    logic [31:0] element_value;
  } ils_req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [6:0]  count;
  } ils_rsp_t;

  typedef struct packed {
    logic       load_req;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_sel;
    logic [2:0] ptr_op;
    logic [1:0] cnt_op;
    logic       got_load;
    logic       sts_load;
    logic [1:0] sts_code;
    logic       emit;
  } ils_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       tgt_lt_cnt;
    logic       tgt_le_cnt;
    logic       ptr_at_tgt;
    logic       ptr_at_last;
    logic       out_free;
  } ils_sts_t;

endpackage

// ===== rtl/core/ils_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Entry memory, fill count, sweep pointer, request hold and response register.
// ----------------------------------------------------------------------------
module ils_datapath #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ils_pkg::ils_req_t in_data,
  input  ils_pkg::ils_cmd_t cmd,
  output ils_pkg::ils_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output ils_pkg::ils_rsp_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;

  ils_pkg::ils_req_t     req_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [WORD_WIDTH-1:0] got_r;
  logic [1:0]            sts_code_r;
  logic                  out_valid_r;
  ils_pkg::ils_rsp_t     out_data_r;

  logic [LW-1:0]          cnt_ext, pos_ext, ptr_ext, tgt;
  logic [CW-1:0]          ptr_dn, ptr_up, cnt_dn;
  logic [AW-1:0]          raddr, waddr;
  logic [WORD_WIDTH-1:0]  wdata, word;
  logic [WORD_WIDTH+31:0] word_ext;
  logic [WORD_WIDTH+31:0] got_ext;

  assign cnt_ext  = LW'(cnt_r);
  assign pos_ext  = LW'(req_r.position);
  assign ptr_ext  = LW'(ptr_r);
  assign ptr_dn   = ptr_r - CW'(1);
  assign ptr_up   = ptr_r + CW'(1);
  assign cnt_dn   = cnt_r - CW'(1);
  assign word_ext = {{WORD_WIDTH{1'b0}}, req_r.element_value};
  assign word     = word_ext[WORD_WIDTH-1:0];
  assign got_ext  = {32'd0, got_r};

  // Position the operation works on
  always_comb begin
    case (req_r.op)
      ils_pkg::OP_APPEND:    tgt = cnt_ext;
      ils_pkg::OP_PREPEND,
      ils_pkg::OP_POP_FRONT: tgt = '0;
      default:               tgt = pos_ext;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      ils_pkg::RD_TGT:    raddr = tgt[AW-1:0];
      ils_pkg::RD_LAST:   raddr = cnt_dn[AW-1:0];
      ils_pkg::RD_PTR_DN: raddr = ptr_dn[AW-1:0];
      default:            raddr = ptr_up[AW-1:0];
    endcase
  end

  always_comb begin
    if (cmd.wr_sel == ils_pkg::WR_RDATA_PTR) begin
      waddr = ptr_r[AW-1:0];
      wdata = rdata_r;
    end else begin
      waddr = tgt[AW-1:0];
      wdata = word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      ils_pkg::PTR_LOAD_CNT: ptr_nxt = cnt_r;
      ils_pkg::PTR_ZERO:     ptr_nxt = '0;
      ils_pkg::PTR_DEC:      ptr_nxt = ptr_dn;
      ils_pkg::PTR_INC:      ptr_nxt = ptr_up;
      default:               ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      ils_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
      ils_pkg::CNT_DEC: cnt_nxt = cnt_dn;
      default:          cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load_req) begin
      req_r <= in_data;
      got_r <= '0;
    end else if (cmd.got_load) begin
      got_r <= rdata_r;
    end
    if (cmd.sts_load) begin
      sts_code_r <= cmd.sts_code;
    end
    if (cmd.emit) begin
      out_data_r.read_value <= got_ext[31:0];
      out_data_r.status     <= sts_code_r;
      out_data_r.count      <= cnt_ext[6:0];
    end
  end

  assign sts.op          = req_r.op;
  assign sts.empty       = (cnt_r == '0);
  assign sts.full        = (cnt_r == CW'(DEPTH));
  assign sts.tgt_lt_cnt  = (tgt < cnt_ext);
  assign sts.tgt_le_cnt  = (tgt <= cnt_ext);
  assign sts.ptr_at_tgt  = (ptr_ext == tgt);
  assign sts.ptr_at_last = (ptr_up == cnt_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/ils_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store controller
// Decodes a request and steps the datapath through reads, shifts and the
// response hand-off.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ils_pkg::ils_sts_t sts,
  output ils_pkg::ils_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SU_RD  = 3'd3;
  localparam logic [2:0] S_SU_WR  = 3'd4;
  localparam logic [2:0] S_SD_RD  = 3'd5;
  localparam logic [2:0] S_SD_WR  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = ils_pkg::RD_TGT;
    cmd.wr_sel   = ils_pkg::WR_WORD_TGT;
    cmd.ptr_op   = ils_pkg::PTR_HOLD;
    cmd.cnt_op   = ils_pkg::CNT_HOLD;
    cmd.sts_code = ils_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.sts_load = 1'b1;
        cmd.sts_code = ils_pkg::ST_RANGE;
        state_nxt    = S_FINISH;
        case (sts.op)
          ils_pkg::OP_APPEND, ils_pkg::OP_PREPEND, ils_pkg::OP_INSERT: begin
            // range check comes before the full check
            if (sts.op == ils_pkg::OP_INSERT && !sts.tgt_le_cnt) begin
              cmd.sts_code = ils_pkg::ST_RANGE;
            end else if (sts.full) begin
              cmd.sts_code = ils_pkg::ST_FULL;
            end else begin
              cmd.sts_code = ils_pkg::ST_OK;
              cmd.ptr_op   = ils_pkg::PTR_LOAD_CNT;
              state_nxt    = S_SU_RD;
            end
          end
          ils_pkg::OP_POP_BACK: begin
            if (!sts.empty) begin
              cmd.sts_code = ils_pkg::ST_OK;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ils_pkg::RD_LAST;
              cmd.cnt_op   = ils_pkg::CNT_DEC;
              state_nxt    = S_RDWAIT;
            end
          end
          ils_pkg::OP_POP_FRONT: begin
            if (!sts.empty) begin
              cmd.sts_code = ils_pkg::ST_OK;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ils_pkg::RD_TGT;
              cmd.ptr_op   = ils_pkg::PTR_ZERO;
              state_nxt    = S_RDWAIT;
            end
          end
          ils_pkg::OP_READ: begin
            if (sts.tgt_lt_cnt) begin
              cmd.sts_code = ils_pkg::ST_OK;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = ils_pkg::RD_TGT;
              state_nxt    = S_RDWAIT;
            end
          end
          ils_pkg::OP_WRITE: begin
            if (sts.tgt_lt_cnt) begin
              cmd.sts_code = ils_pkg::ST_OK;
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = ils_pkg::WR_WORD_TGT;
            end
          end
          default: begin
            cmd.sts_code = ils_pkg::ST_RANGE;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.got_load = 1'b1;
        state_nxt    = (sts.op == ils_pkg::OP_POP_FRONT) ? S_SD_RD : S_FINISH;
      end
      S_SU_RD: begin
        // slot open: drop the new word in and grow the list
        if (sts.ptr_at_tgt) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ils_pkg::WR_WORD_TGT;
          cmd.cnt_op = ils_pkg::CNT_INC;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_PTR_DN;
          state_nxt  = S_SU_WR;
        end
      end
      S_SU_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ils_pkg::WR_RDATA_PTR;
        cmd.ptr_op = ils_pkg::PTR_DEC;
        state_nxt  = S_SU_RD;
      end
      S_SD_RD: begin
        if (sts.ptr_at_last) begin
          cmd.cnt_op = ils_pkg::CNT_DEC;
          state_nxt  = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_PTR_UP;
          state_nxt  = S_SD_WR;
        end
      end
      S_SD_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ils_pkg::WR_RDATA_PTR;
        cmd.ptr_op = ils_pkg::PTR_INC;
        state_nxt  = S_SD_RD;
      end
      S_FINISH: begin
        // hold until the response register is free
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/indexed_list_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store unit
// Ordered list of up to DEPTH words with end, front and indexed access.
// ----------------------------------------------------------------------------
// One request is worked on at a time, stepped by a controller over a single
// entry RAM with one write and one registered read port. Prepend and insert
// move each entry from the insert position up to the end with a read and a
// write; remove-from-front moves each later entry down one place the same
// way. The response waits in an output register, so a new request is taken
// while the previous response is still pending; the block holds in its last
// step only while that register is still occupied.
// ----------------------------------------------------------------------------
module indexed_list_store_unit #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ils_pkg::ils_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ils_pkg::ils_rsp_t out_data
);

  ils_pkg::ils_cmd_t cmd;
  ils_pkg::ils_sts_t sts;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ils_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/ils_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store port checker
// Watches the top-level ports for response rules and hand-off behaviour.
// ----------------------------------------------------------------------------
`include "indexed_list_store_unit_defines.svh"

module ils_checker #(
  parameter int DEPTH = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ils_pkg::ils_rsp_t out_data
);

  logic in_take, rsp_stall, rsp_bad, rsp_full;

  assign in_take   = in_valid && in_ready;
  assign rsp_stall = out_valid && !out_ready;
  assign rsp_bad   = out_valid && (out_data.status != ils_pkg::ST_OK);
  assign rsp_full  = out_valid && (out_data.status == ils_pkg::ST_FULL);

  // A stalled response must hold
  `ILS_ASSERT_NXT(a_rsp_hold, rsp_stall, out_valid && $stable(out_data), "response moved")

  // Only an ok request carries a word back
  `ILS_ASSERT_IMP(a_rsp_zero, rsp_bad, out_data.read_value == 32'd0, "word with failing status")

  // A full rejection means the list sits at capacity
  `ILS_ASSERT_IMP(a_full_cnt, rsp_full, out_data.count == 7'(DEPTH), "full status below capacity")

  // Length never exceeds capacity
  `ILS_ASSERT_IMP(a_cnt_cap, out_valid, 32'(out_data.count) <= 32'(DEPTH), "length above capacity")

  // One request at a time: drop ready after taking one
  `ILS_ASSERT_NXT(a_in_one, in_take, !in_ready, "ready held after a request")

endmodule

bind indexed_list_store_unit ils_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store unit testbench
// Drives list requests over the valid/ready request channel, predicts every
// response with an in-bench list model and checks each response in order.
// The stimulus starts with hand-picked corner requests, then runs random
// requests in growing, mixed and shrinking spells so the list reaches full
// and empty repeatedly. Sender and receiver idle at random, and the receiver
// holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIST_DEPTH    = 64;
  localparam int RANDOM_ITEMS  = 525;
  localparam int SPELL_LEN     = 50;
  localparam int HOLD_AT       = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 300;

  localparam int TREND_GROW   = 0;
  localparam int TREND_SHRINK = 1;
  localparam int TREND_MIXED  = 2;

  // op code with no operation behind it
  localparam logic [2:0] OP_RESERVED = 3'd7;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ils_pkg::ils_req_t in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ils_pkg::ils_rsp_t out_data;

  // list model state
  logic [31:0] list_words [LIST_DEPTH];
  int          list_len = 0;

  ils_pkg::ils_req_t req_backlog[$];
  ils_pkg::ils_rsp_t pending_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int fails         = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int peak_len      = 0;
  int full_seen     = 0;
  int range_seen    = 0;

  indexed_list_store_unit #(
    .DEPTH      (LIST_DEPTH),
    .WORD_WIDTH (32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Open a slot at pos, moving the later entries up one place
  function automatic void open_slot_at(int pos, logic [31:0] word);
    for (int i = list_len; i > pos; i--) begin
      list_words[i] = list_words[i - 1];
    end
    list_words[pos] = word;
    list_len++;
  endfunction

  function automatic ils_pkg::ils_rsp_t apply_list_op(ils_pkg::ils_req_t req);
    ils_pkg::ils_rsp_t rsp;
    logic [31:0]       word;
    int                pos;
    rsp  = '0;
    word = '0;
    pos  = int'(req.position);
    rsp.status = ils_pkg::ST_OK;
    case (req.op)
      ils_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH) rsp.status = ils_pkg::ST_FULL;
        else open_slot_at(list_len, req.element_value);
      end
      ils_pkg::OP_POP_BACK: begin
        if (list_len == 0) begin
          rsp.status = ils_pkg::ST_RANGE;
        end else begin
          list_len--;
          word = list_words[list_len];
        end
      end
      ils_pkg::OP_PREPEND: begin
        if (list_len >= LIST_DEPTH) rsp.status = ils_pkg::ST_FULL;
        else open_slot_at(0, req.element_value);
      end
      ils_pkg::OP_POP_FRONT: begin
        if (list_len == 0) begin
          rsp.status = ils_pkg::ST_RANGE;
        end else begin
          word = list_words[0];
          for (int i = 0; i + 1 < list_len; i++) begin
            list_words[i] = list_words[i + 1];
          end
          list_len--;
        end
      end
      ils_pkg::OP_READ: begin
        if (pos >= list_len) rsp.status = ils_pkg::ST_RANGE;
        else word = list_words[pos];
      end
      ils_pkg::OP_WRITE: begin
        if (pos >= list_len) rsp.status = ils_pkg::ST_RANGE;
        else list_words[pos] = req.element_value;
      end
      ils_pkg::OP_INSERT: begin
        // range check comes before the full check
        if (pos > list_len) rsp.status = ils_pkg::ST_RANGE;
        else if (list_len >= LIST_DEPTH) rsp.status = ils_pkg::ST_FULL;
        else open_slot_at(pos, req.element_value);
      end
      default: rsp.status = ils_pkg::ST_RANGE;
    endcase
    rsp.read_value = (rsp.status == ils_pkg::ST_OK) ? word : 32'd0;
    rsp.count      = 7'(list_len);
    return rsp;
  endfunction

  function automatic ils_pkg::ils_req_t pick_request(int trend);
    ils_pkg::ils_req_t req;
    int                roll;
    int                len;
    int                push_lim;
    int                pop_lim;
    len = list_len;
    req.element_value = $urandom;
    roll = $urandom_range(9);
    if (roll == 0) req.element_value = 32'd0;
    else if (roll == 1) req.element_value = 32'hFFFF_FFFF;
    req.position = 7'($urandom_range(127));
    // plain noise: any op code, any position
    if ($urandom_range(9) == 0) begin
      req.op = 3'($urandom_range(7));
      return req;
    end
    case (trend)
      TREND_GROW:   begin push_lim = 70; pop_lim = 80; end
      TREND_SHRINK: begin push_lim = 25; pop_lim = 75; end
      default:      begin push_lim = 40; pop_lim = 60; end
    endcase
    roll = $urandom_range(99);
    if (roll < push_lim) begin
      case ($urandom_range(2))
        0:       req.op = ils_pkg::OP_APPEND;
        1:       req.op = ils_pkg::OP_PREPEND;
        default: req.op = ils_pkg::OP_INSERT;
      endcase
    end else if (roll < pop_lim) begin
      req.op = ($urandom_range(1) == 0) ? ils_pkg::OP_POP_BACK : ils_pkg::OP_POP_FRONT;
    end else begin
      req.op = ($urandom_range(1) == 0) ? ils_pkg::OP_READ : ils_pkg::OP_WRITE;
    end
    // keep most indexed requests inside the list
    if ($urandom_range(9) != 0) begin
      if (req.op == ils_pkg::OP_INSERT) req.position = 7'($urandom_range(len));
      else if (len > 0) req.position = 7'($urandom_range(len - 1));
    end
    return req;
  endfunction

  // Request driver
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_replies.push_back(apply_list_op(in_data));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver
  always @(posedge clk) begin : watch_responses
    ils_pkg::ils_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $error("response with no request outstanding: %h", out_data);
          fails++;
        end else begin
          want = pending_replies.pop_front();
          checked_count++;
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_data.read_value);
            fails++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            fails++;
          end
          if (int'(want.count) > peak_len) peak_len = int'(want.count);
          if (want.status == ils_pkg::ST_FULL) full_seen++;
          if (want.status == ils_pkg::ST_RANGE) range_seen++;
        end
      end
      // hold off once for a long stretch so the block backs up
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_request(logic [2:0] op, int pos, logic [31:0] word);
    ils_pkg::ils_req_t req;
    req.op            = op;
    req.position      = 7'(pos);
    req.element_value = word;
    req_backlog.push_back(req);
  endtask

  initial begin : stimulus
    ils_pkg::ils_req_t req;
    int                useful;
    int                trend;
    send_idle_pct = 30;
    recv_idle_pct = 47;

    // corners on an empty list
    queue_request(ils_pkg::OP_POP_BACK, 0, 32'h1111_1111);
    queue_request(ils_pkg::OP_POP_FRONT, 0, 32'h2222_2222);
    queue_request(ils_pkg::OP_READ, 0, 32'd0);
    queue_request(ils_pkg::OP_WRITE, 0, 32'hDEAD_BEEF);
    queue_request(ils_pkg::OP_INSERT, 1, 32'h3333_3333);
    queue_request(OP_RESERVED, 0, 32'h4444_4444);
    // insert at the end behaves as an append
    queue_request(ils_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
    queue_request(ils_pkg::OP_APPEND, 127, 32'd0);
    queue_request(ils_pkg::OP_PREPEND, 127, 32'hA5A5_A5A5);
    queue_request(ils_pkg::OP_INSERT, 1, 32'h5A5A_5A5A);
    queue_request(ils_pkg::OP_INSERT, 4, 32'd1);
    queue_request(ils_pkg::OP_READ, 0, 32'd0);
    queue_request(ils_pkg::OP_READ, 4, 32'hFFFF_FFFF);
    queue_request(ils_pkg::OP_READ, 5, 32'd0);
    queue_request(ils_pkg::OP_READ, 127, 32'd0);
    queue_request(ils_pkg::OP_WRITE, 2, 32'hFFFF_FFFF);
    queue_request(ils_pkg::OP_READ, 2, 32'd0);
    queue_request(ils_pkg::OP_WRITE, 64, 32'h8000_0000);
    queue_request(ils_pkg::OP_INSERT, 127, 32'h7FFF_FFFF);
    queue_request(ils_pkg::OP_POP_FRONT, 0, 32'd0);
    queue_request(ils_pkg::OP_POP_BACK, 0, 32'd0);
    queue_request(OP_RESERVED, 127, 32'hFFFF_FFFF);
    queue_request(ils_pkg::OP_READ, 0, 32'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      @(negedge clk);
      while (req_backlog.size() >= 2) @(negedge clk);
      case ((useful / SPELL_LEN) % 4)
        0, 1:    trend = TREND_GROW;
        2:       trend = TREND_MIXED;
        default: trend = TREND_SHRINK;
      endcase
      if (useful == 180) begin
        send_idle_pct = 47;
        recv_idle_pct = 30;
      end else if (useful == 360) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      req = pick_request(trend);
      req_backlog.push_back(req);
      if (req.op != OP_RESERVED) useful++;
    end

    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || pending_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d responses.", sent_count, checked_count);
    $display("Peak length %0d, %0d full rejections, %0d empty or range rejections.",
             peak_len, full_seen, range_seen);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ils_pkg.sv
rtl/core/ils_datapath.sv
rtl/core/ils_ctrl.sv
rtl/core/indexed_list_store_unit.sv
rtl/core/ils_checker.sv
tb/sv/tb.sv
